// ===== sv/rtc_calendar_register_file_assert.svh =====
// Assertion macros shared by the RTC calendar register file RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef RTC_CALENDAR_REGISTER_FILE_ASSERT_SVH
`define RTC_CALENDAR_REGISTER_FILE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RCRF_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcrf: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define RCRF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcrf: next-cycle check failed");

`endif

// ===== sv/rcrf_pkg.sv =====
// Shared types, constants and BCD helpers for the RTC calendar register file.
// No dependencies; used by the calendar block and the top level.
package rcrf_pkg;

  localparam int FILE_BYTES_DEF = 40;
  localparam int CAL_BYTES      = 8;
  localparam int CAL_AW         = 3;

  // Request kinds carried on the input tuser
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Calendar byte positions
  localparam logic [CAL_AW-1:0] IDX_SEC   = 3'd0;
  localparam logic [CAL_AW-1:0] IDX_MIN   = 3'd1;
  localparam logic [CAL_AW-1:0] IDX_HOUR  = 3'd2;
  localparam logic [CAL_AW-1:0] IDX_WDAY  = 3'd3;
  localparam logic [CAL_AW-1:0] IDX_DATE  = 3'd4;
  localparam logic [CAL_AW-1:0] IDX_MONTH = 3'd5;
  localparam logic [CAL_AW-1:0] IDX_YEAR  = 3'd6;
  localparam logic [CAL_AW-1:0] IDX_CTRL  = 3'd7;

  localparam logic [7:0] MAX_SEC      = 8'd59;
  localparam logic [7:0] MAX_MIN      = 8'd59;
  localparam logic [7:0] MAX_HOUR     = 8'd23;
  localparam logic [7:0] MAX_WDAY     = 8'd7;
  localparam logic [7:0] DAYS_SHORT   = 8'd30;
  localparam logic [7:0] DAYS_LONG    = 8'd31;
  localparam logic [7:0] DAYS_FEB     = 8'd28;
  localparam logic [7:0] DAYS_FEB_LP  = 8'd29;
  localparam logic [7:0] MONTHS       = 8'd12;
  localparam logic [7:0] HI_NIBBLE    = 8'hF0;
  localparam logic [7:0] LO_NIBBLE    = 8'h0F;

  localparam logic [7:0] RST_WDAY  = 8'd7;
  localparam logic [7:0] RST_DATE  = 8'd1;
  localparam logic [7:0] RST_MONTH = 8'd1;
  localparam logic [7:0] RST_YEAR  = 8'd12;

  localparam logic [7:0] CFG_BCD_ADDR = 8'd0;

  typedef struct packed {
    logic              tick;
    logic              wr;
    logic [CAL_AW-1:0] addr;
    logic [7:0]        wdata;
  } cal_req_t;

  // Binary to BCD; values over 99 do not fit: the tens nibble holds the tens count modulo 16
  function automatic logic [7:0] to_bcd(input logic [7:0] v);
    logic [15:0] prod;
    logic [4:0]  tens;
    logic [7:0]  ones;
    prod = 16'(v) * 16'd205;
    tens = prod[15:11];
    ones = 8'(v - 8'(8'(tens) * 8'd10));
    return {tens[3:0], ones[3:0]};
  endfunction

  // BCD to binary, no digit check
  function automatic logic [7:0] from_bcd(input logic [7:0] v);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = (v & HI_NIBBLE) >> 4;
    lo = v & LO_NIBBLE;
    return 8'((hi << 3) + (hi << 1) + lo);
  endfunction

endpackage

// ===== sv/rtc_calendar_register_file.sv =====
// Top level of the RTC calendar register file: stream ports, APB config,
// two-stage result pipeline. Depends on rcrf_pkg, rcrf_calendar, rcrf_ram.
//
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid/tready             tuser op, tdata address+write_data
//  m_axis    out        tvalid/tready             tdata read_data, tuser out_of_range
//  apb       in         psel/penable/pwrite       register 0 bcd_en at byte 0
//
// One request per cycle while the output is not stalled; its result is held in stage 1, then in the result register.
// Calendar update, writes and the RAM read are done at the accepting edge,
// BCD conversion of read data in the second stage; the RAM read port sets
// the latency. Reset restores the calendar to its default date, clears
// bcd_en and empties the pipeline; RAM bytes read as zero until written.
// A stalled output holds both stages; input is refused only when both are full.
`include "rtc_calendar_register_file_assert.svh"

module rtc_calendar_register_file #(
  parameter int FILE_BYTES = rcrf_pkg::FILE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [6:0] address, [14:7] write_data, [15] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] read_data
  output logic        m_axis_tuser,   // [0] out_of_range
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RamDepth = (FILE_BYTES > rcrf_pkg::CAL_BYTES) ?
                            FILE_BYTES - rcrf_pkg::CAL_BYTES : 1;
  localparam int RamAw    = (RamDepth > 1) ? $clog2(RamDepth) : 1;
  localparam logic [7:0] FileLimit = 8'(FILE_BYTES);

  // config register
  logic bcd_q;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'b0, bcd_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      bcd_q <= pwdata[0];
    end
  end

  // request decode
  logic       acc, adv1;
  logic [1:0] op;
  logic [6:0] addr;
  logic [7:0] wdata, wbyte;
  logic       in_range, is_cal, is_rd, is_wr;
  logic [6:0] ram_idx;
  logic       ram_we, ram_re;

  assign op       = s_axis_tuser;
  assign addr     = s_axis_tdata[6:0];
  assign wdata    = s_axis_tdata[14:7];
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign in_range = {1'b0, addr} < FileLimit;
  assign is_cal   = addr[6:3] == '0;
  assign is_rd    = op == rcrf_pkg::OP_READ;
  assign is_wr    = op == rcrf_pkg::OP_WRITE;
  assign wbyte    = bcd_q ? rcrf_pkg::from_bcd(wdata) : wdata;
  assign ram_idx  = 7'(addr - 7'(rcrf_pkg::CAL_BYTES));
  assign ram_we   = acc && is_wr && in_range && !is_cal;
  assign ram_re   = acc && is_rd && in_range && !is_cal;

  rcrf_pkg::cal_req_t cal_req;
  logic [7:0]         cal_rdata, ram_rdata;

  always_comb begin
    cal_req.tick  = acc && (op == rcrf_pkg::OP_TICK);
    cal_req.wr    = acc && is_wr && in_range && is_cal;
    cal_req.addr  = addr[rcrf_pkg::CAL_AW-1:0];
    cal_req.wdata = wbyte;
  end

  rcrf_calendar u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cal_req),
    .raddr_i (addr[rcrf_pkg::CAL_AW-1:0]),
    .rdata_o (cal_rdata)
  );

  rcrf_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth),
    .AW    (RamAw)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_idx[RamAw-1:0]),
    .wdata_i (wbyte),
    .re_i    (ram_re),
    .raddr_i (ram_idx[RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // mark RAM bytes once written; unmarked bytes read as zero
  logic [RamDepth-1:0] ram_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_vld_q <= '0;
    end else if (ram_we) begin
      ram_vld_q[ram_idx[RamAw-1:0]] <= 1'b1;
    end
  end

  // stage 1: raw byte and flags
  logic       s1_valid_q, s1_rd_q, s1_ram_q, s1_ramv_q, s1_oor_q;
  logic [7:0] s1_cal_q;
  // stage 2: result register
  logic       out_valid_q, out_oor_q;
  logic [7:0] out_data_q, s2_byte, s2_data;

  assign adv1          = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_rd_q   <= is_rd && in_range;
      s1_ram_q  <= !is_cal;
      s1_ramv_q <= ram_vld_q[ram_idx[RamAw-1:0]];
      s1_oor_q  <= (is_rd || is_wr) && !in_range;
      s1_cal_q  <= cal_rdata;
    end
    if (adv1 && s1_valid_q) begin
      out_data_q <= s2_data;
      out_oor_q  <= s1_oor_q;
    end
  end

  always_comb begin
    s2_byte = s1_ram_q ? (s1_ramv_q ? ram_rdata : 8'd0) : s1_cal_q;
    s2_data = '0;
    if (s1_rd_q) begin
      s2_data = bcd_q ? rcrf_pkg::to_bcd(s2_byte) : s2_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_oor_q;

  `RCRF_ASSERT_SAME(a_oor_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `RCRF_ASSERT_SAME(a_full_stall, clk_i, rst_ni, s1_valid_q && out_valid_q && !m_axis_tready, !s_axis_tready)

endmodule

// ===== sv/rcrf_ram.sv =====
// Generic single-port-write, registered-read RAM for the general bytes.
// No dependencies.
module rcrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rcrf_calendar.sv =====
// Calendar bytes 0..7 in flops: one-second tick, byte writes and byte reads.
// Depends on rcrf_pkg and the assertion macro header.
`include "rtc_calendar_register_file_assert.svh"

module rcrf_calendar (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcrf_pkg::cal_req_t req_i,
  input  logic [rcrf_pkg::CAL_AW-1:0] raddr_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] cal_q [rcrf_pkg::CAL_BYTES];
  logic [7:0] cal_d [rcrf_pkg::CAL_BYTES];

  logic [7:0] sec1, min1, hour1, date1, wday1, mon, mon1, year1;
  logic       c_sec, c_min, c_hour, roll;
  logic [7:0] limit;
  logic       long_month;

  always_comb begin
    sec1  = cal_q[rcrf_pkg::IDX_SEC] + 8'd1;
    c_sec = sec1 > rcrf_pkg::MAX_SEC;
    if (c_sec) begin
      sec1 = '0;
    end
    min1  = cal_q[rcrf_pkg::IDX_MIN] + 8'(c_sec);
    c_min = min1 > rcrf_pkg::MAX_MIN;
    if (c_min) begin
      min1 = '0;
    end
    hour1  = cal_q[rcrf_pkg::IDX_HOUR] + 8'(c_min);
    c_hour = hour1 > rcrf_pkg::MAX_HOUR;
    if (c_hour) begin
      hour1 = '0;
    end
    date1 = cal_q[rcrf_pkg::IDX_DATE] + 8'(c_hour);
    wday1 = cal_q[rcrf_pkg::IDX_WDAY] + 8'(c_hour);
    if (c_hour && (wday1 > rcrf_pkg::MAX_WDAY)) begin
      wday1 = 8'd1;
    end

    // month length; a month byte outside 1..12 never rolls the date
    mon        = cal_q[rcrf_pkg::IDX_MONTH];
    long_month = 1'b0;
    limit      = 8'hFF;
    case (mon)
      8'd4, 8'd6, 8'd9, 8'd11: limit = rcrf_pkg::DAYS_SHORT;
      8'd2: limit = (cal_q[rcrf_pkg::IDX_YEAR][1:0] == 2'b00) ?
                    rcrf_pkg::DAYS_FEB_LP : rcrf_pkg::DAYS_FEB;
      8'd1, 8'd3, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12: begin
        limit      = rcrf_pkg::DAYS_LONG;
        long_month = 1'b1;
      end
      default: limit = 8'hFF;
    endcase
    roll  = (limit != 8'hFF) && (date1 > limit);
    mon1  = mon;
    year1 = cal_q[rcrf_pkg::IDX_YEAR];
    if (roll) begin
      date1 = 8'd1;
      mon1  = mon + 8'd1;
      if (long_month && (mon1 > rcrf_pkg::MONTHS)) begin
        mon1  = 8'd1;
        year1 = year1 + 8'd1;
      end
    end

    for (int i = 0; i < rcrf_pkg::CAL_BYTES; i++) begin
      cal_d[i] = cal_q[i];
    end
    if (req_i.tick) begin
      cal_d[rcrf_pkg::IDX_SEC]   = sec1;
      cal_d[rcrf_pkg::IDX_MIN]   = min1;
      cal_d[rcrf_pkg::IDX_HOUR]  = hour1;
      cal_d[rcrf_pkg::IDX_WDAY]  = wday1;
      cal_d[rcrf_pkg::IDX_DATE]  = date1;
      cal_d[rcrf_pkg::IDX_MONTH] = mon1;
      cal_d[rcrf_pkg::IDX_YEAR]  = year1;
    end else if (req_i.wr) begin
      cal_d[req_i.addr] = req_i.wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rcrf_pkg::CAL_BYTES; i++) begin
        cal_q[i] <= '0;
      end
      cal_q[rcrf_pkg::IDX_WDAY]  <= rcrf_pkg::RST_WDAY;
      cal_q[rcrf_pkg::IDX_DATE]  <= rcrf_pkg::RST_DATE;
      cal_q[rcrf_pkg::IDX_MONTH] <= rcrf_pkg::RST_MONTH;
      cal_q[rcrf_pkg::IDX_YEAR]  <= rcrf_pkg::RST_YEAR;
    end else begin
      for (int i = 0; i < rcrf_pkg::CAL_BYTES; i++) begin
        cal_q[i] <= cal_d[i];
      end
    end
  end

  assign rdata_o = cal_q[raddr_i];

  `RCRF_ASSERT_NEXT(a_tick_bounds, clk_i, rst_ni, req_i.tick, (cal_q[rcrf_pkg::IDX_SEC] <= rcrf_pkg::MAX_SEC) && (cal_q[rcrf_pkg::IDX_MIN] <= rcrf_pkg::MAX_MIN) && (cal_q[rcrf_pkg::IDX_HOUR] <= rcrf_pkg::MAX_HOUR))
  `RCRF_ASSERT_NEXT(a_sec_write, clk_i, rst_ni, req_i.wr && !req_i.tick && (req_i.addr == rcrf_pkg::IDX_SEC), cal_q[rcrf_pkg::IDX_SEC] == $past(req_i.wdata))

endmodule
